// ===== hdl/ftu_pkg.sv =====
// ----------------------------------------------------------------------------
// ftu_pkg
// shared types, register map constants and codes of the timer unit
// ----------------------------------------------------------------------------
package ftu_pkg;

    localparam int MAX_CHANNELS       = 5;
    localparam int DEFAULT_CHANNELS   = 5;
    localparam int DEFAULT_CYCLE_BITS = 10;
    localparam int IRQ_W              = 3 * MAX_CHANNELS;

    localparam logic [7:0]  START_OFFSET   = 8'h60;
    localparam logic [7:0]  START_RESET    = 8'he0;
    localparam logic [7:0]  FORCED_BITS    = 8'hf8;
    localparam logic [15:0] COMPARE_RESET  = 16'hffff;
    localparam logic [16:0] FREE_WRAP      = 17'h10000;
    localparam logic [7:0]  WINDOW_SPAN    = 8'd9;

    // channel window base offsets
    localparam logic [7:0] WINDOW_BASE [MAX_CHANNELS] = '{8'h64, 8'h6e, 8'h78, 8'h82, 8'h92};

    // clear select codes in control bits 6:5
    localparam logic [1:0] CLR_ON_A = 2'b01;
    localparam logic [1:0] CLR_ON_B = 2'b10;

    typedef enum logic [1:0] {
        MODE_ADVANCE = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_READ    = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        SUB_CTL    = 4'd0,
        SUB_IOC    = 4'd1,
        SUB_IER    = 4'd2,
        SUB_STAT   = 4'd3,
        SUB_CNT_H  = 4'd4,
        SUB_CNT_L  = 4'd5,
        SUB_CMPA_H = 4'd6,
        SUB_CMPA_L = 4'd7,
        SUB_CMPB_H = 4'd8,
        SUB_CMPB_L = 4'd9
    } t_sub;

    typedef struct packed {
        logic                    start_hit;
        logic [MAX_CHANNELS-1:0] ch_hit;
        t_sub                    sub;
    } t_decode;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       wr;
        t_sub       sub;
        logic [7:0] wdata;
    } t_chan_ctl;

    typedef struct packed {
        logic       idle;
        logic [2:0] raised;
        logic [7:0] rdata;
    } t_chan_stat;

endpackage

// ===== hdl/five_channel_timer_unit.sv =====
// ----------------------------------------------------------------------------
// five_channel_timer_unit
// five 16-bit timer channels behind a byte-wide register window
// ----------------------------------------------------------------------------
// usage
//   a transaction is accepted at a rising edge with i_start high and o_busy
//   low; i_mode picks advance (0), register byte write (1) or read (2)
//   every transaction gives exactly one result: o_done is high for one cycle
//   with o_read_data and o_irq_raised valid in that cycle
//   write, read and the unused mode go from accept through the exec state to o_done
//   an advance first splits the elapsed cycles into ticks per channel through
//   each prescaler, then every running channel steps its counter one tick per
//   cycle, all channels in parallel, until each has used up its ticks; the
//   largest tick count is residue + elapsed cycles, at most 2^CYCLE_BITS + 6
//   o_busy stays high from accept until o_done; a new transaction may be
//   accepted in the cycle o_done is shown
//   reset (synchronous, active low) returns all registers but the held payload
//   to their reset values at once and drops o_busy and o_done
//   the receiver cannot stall: each result is taken in its o_done cycle
// ----------------------------------------------------------------------------
module five_channel_timer_unit #(
    parameter int CHANNELS   = ftu_pkg::DEFAULT_CHANNELS,
    parameter int CYCLE_BITS = ftu_pkg::DEFAULT_CYCLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_mode,
    input  logic [7:0]                  i_reg_offset,
    input  logic [7:0]                  i_write_data,
    input  logic [CYCLE_BITS-1:0]       i_elapsed_cycles,
    output logic                        o_done,
    output logic [7:0]                  o_read_data,
    output logic [ftu_pkg::IRQ_W-1:0]   o_irq_raised
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RUN
    } t_state;

    t_state                    r_state;
    logic                      r_done;
    logic [7:0]                r_rd;
    logic [ftu_pkg::IRQ_W-1:0] r_irq;

    // transaction payload, held while busy
    logic [1:0]            r_mode;
    logic [7:0]            r_offset;
    logic [7:0]            r_wdata;
    logic [CYCLE_BITS-1:0] r_cycles;

    logic [7:0] r_start_bits;

    ftu_pkg::t_decode    dec;
    ftu_pkg::t_chan_ctl  ctl  [CHANNELS];
    ftu_pkg::t_chan_stat stat [CHANNELS];

    logic                      accept;
    logic                      all_idle;
    logic [7:0]                rd_mux;
    logic [ftu_pkg::IRQ_W-1:0] irq_mux;

    assign accept = i_start && (r_state == ST_IDLE);

    // offset decode of the held transaction
    ftu_decode #(
        .CHANNELS (CHANNELS)
    ) u_decode (
        .i_offset (r_offset),
        .o_dec    (dec)
    );

    // channel controls: load splits ticks, step runs one tick in every channel with ticks left
    generate
        for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
            always_comb begin
                ctl[g].load  = (r_state == ST_EXEC) &&
                               (r_mode == ftu_pkg::MODE_ADVANCE);
                ctl[g].step  = (r_state == ST_RUN);
                ctl[g].wr    = (r_state == ST_EXEC) &&
                               (r_mode == ftu_pkg::MODE_WRITE) && dec.ch_hit[g];
                ctl[g].sub   = dec.sub;
                ctl[g].wdata = r_wdata;
            end

            ftu_channel #(
                .CYCLE_BITS (CYCLE_BITS)
            ) u_channel (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_enable (r_start_bits[g]),
                .i_cycles (r_cycles),
                .i_ctl    (ctl[g]),
                .o_stat   (stat[g])
            );
        end
    endgenerate

    // gather read data, request bits and the run-complete condition
    always_comb begin
        all_idle = 1'b1;
        rd_mux   = dec.start_hit ? r_start_bits : 8'd0;
        irq_mux  = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            all_idle = all_idle & stat[i].idle;
            if (dec.ch_hit[i]) begin
                rd_mux = rd_mux | stat[i].rdata;
            end
            irq_mux[3*i +: 3] = stat[i].raised;
        end
    end

    // start register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bits <= ftu_pkg::START_RESET;
        end else if (r_state == ST_EXEC && r_mode == ftu_pkg::MODE_WRITE &&
                     dec.start_hit) begin
            r_start_bits <= r_wdata;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_offset <= i_reg_offset;
            r_wdata  <= i_write_data;
            r_cycles <= i_elapsed_cycles;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_rd    <= '0;
            r_irq   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (r_mode == ftu_pkg::MODE_ADVANCE) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_done  <= 1'b1;
                        r_rd    <= (r_mode == ftu_pkg::MODE_READ) ? rd_mux : 8'd0;
                        r_irq   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_RUN: begin
                    // every channel has used up its ticks
                    if (all_idle) begin
                        r_done  <= 1'b1;
                        r_rd    <= '0;
                        r_irq   <= irq_mux;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_read_data  = r_rd;
    assign o_irq_raised = r_irq;

    // results only follow a transaction in progress
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) != ST_IDLE)
        else $error("result strobe without a transaction in progress");

    // request bits only come out of an advance
    a_irq_only_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_irq_raised != '0) |-> r_mode == ftu_pkg::MODE_ADVANCE)
        else $error("request bits raised outside an advance");

    // read data only comes out of a read
    a_rd_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_read_data != 8'd0) |-> r_mode == ftu_pkg::MODE_READ)
        else $error("read data returned outside a read");

    // an accepted transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted transaction did not raise busy");

endmodule

// ===== hdl/ftu_decode.sv =====
// ----------------------------------------------------------------------------
// ftu_decode
// register offset decoder: start register and channel windows
// ----------------------------------------------------------------------------
module ftu_decode #(
    parameter int CHANNELS = ftu_pkg::DEFAULT_CHANNELS
) (
    input  logic [7:0]      i_offset,
    output ftu_pkg::t_decode o_dec
);

    logic [ftu_pkg::MAX_CHANNELS-1:0] hit;
    logic [3:0]                       sub_acc;

    always_comb begin
        hit     = '0;
        sub_acc = '0;
        for (int i = 0; i < ftu_pkg::MAX_CHANNELS; i++) begin
            if (i < CHANNELS && i_offset >= ftu_pkg::WINDOW_BASE[i] &&
                i_offset <= ftu_pkg::WINDOW_BASE[i] + ftu_pkg::WINDOW_SPAN) begin
                hit[i]  = 1'b1;
                sub_acc = sub_acc | 4'(i_offset - ftu_pkg::WINDOW_BASE[i]);
            end
        end
        o_dec.start_hit = (i_offset == ftu_pkg::START_OFFSET);
        o_dec.ch_hit    = hit;
        o_dec.sub       = ftu_pkg::t_sub'(sub_acc);
    end

endmodule

// ===== hdl/ftu_channel.sv =====
// ----------------------------------------------------------------------------
// ftu_channel
// one timer channel: registers, prescale split and single-tick step unit
// ----------------------------------------------------------------------------
module ftu_channel #(
    parameter int CYCLE_BITS = ftu_pkg::DEFAULT_CYCLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_enable,
    input  logic [CYCLE_BITS-1:0]  i_cycles,
    input  ftu_pkg::t_chan_ctl     i_ctl,
    output ftu_pkg::t_chan_stat    o_stat
);

    localparam int SUM_W = ((CYCLE_BITS > 3) ? CYCLE_BITS : 3) + 1;

    logic [7:0]       r_ctl;
    logic [7:0]       r_ioc;
    logic [2:0]       r_ier;
    logic [2:0]       r_flags;
    logic [15:0]      r_count;
    logic [15:0]      r_cmp_a;
    logic [15:0]      r_cmp_b;
    logic [2:0]       r_res;
    logic [SUM_W-1:0] r_ticks;
    logic [2:0]       r_raised;

    logic             active;
    logic [1:0]       sel;
    logic [2:0]       res_mask;
    logic [SUM_W-1:0] sum;
    logic [16:0]      cnt_inc;
    logic [16:0]      cyc;
    logic             wrap;
    logic [15:0]      cnt_next;
    logic [2:0]       new_flags;

    // prescale split
    always_comb begin
        sel      = r_ctl[1:0];
        active   = i_enable && !r_ctl[2];
        res_mask = 3'((4'd1 << sel) - 4'd1);
        sum      = SUM_W'(r_res) + SUM_W'(i_cycles);
    end

    // one counter tick
    always_comb begin
        cnt_inc = {1'b0, r_count} + 17'd1;
        case (r_ctl[6:5])
            ftu_pkg::CLR_ON_A: cyc = {1'b0, r_cmp_a} + 17'd1;
            ftu_pkg::CLR_ON_B: cyc = {1'b0, r_cmp_b} + 17'd1;
            default:           cyc = ftu_pkg::FREE_WRAP;
        endcase
        wrap      = (cyc != ftu_pkg::FREE_WRAP) && (cnt_inc >= cyc);
        cnt_next  = wrap ? 16'd0 : cnt_inc[15:0];
        new_flags = {cnt_inc[16],
                     cnt_next == 16'(r_cmp_b + 16'd1),
                     cnt_next == 16'(r_cmp_a + 16'd1)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '0;
            r_ioc    <= '0;
            r_ier    <= '0;
            r_flags  <= '0;
            r_count  <= '0;
            r_cmp_a  <= ftu_pkg::COMPARE_RESET;
            r_cmp_b  <= ftu_pkg::COMPARE_RESET;
            r_res    <= '0;
            r_ticks  <= '0;
            r_raised <= '0;
        end else if (i_ctl.load) begin
            r_raised <= '0;
            if (active) begin
                r_ticks <= SUM_W'(sum >> sel);
                r_res   <= sum[2:0] & res_mask;
            end else begin
                r_ticks <= '0;
            end
        end else if (i_ctl.step && r_ticks != '0) begin
            r_ticks  <= r_ticks - SUM_W'(1);
            r_count  <= cnt_next;
            r_flags  <= r_flags | new_flags;
            r_raised <= r_raised | (new_flags & r_ier);
        end else if (i_ctl.wr) begin
            unique case (i_ctl.sub)
                ftu_pkg::SUB_CTL:    r_ctl          <= i_ctl.wdata;
                ftu_pkg::SUB_IOC:    r_ioc          <= i_ctl.wdata;
                ftu_pkg::SUB_IER:    r_ier          <= i_ctl.wdata[2:0];
                ftu_pkg::SUB_STAT:   r_flags        <= r_flags & i_ctl.wdata[2:0];
                ftu_pkg::SUB_CNT_H:  r_count[15:8]  <= i_ctl.wdata;
                ftu_pkg::SUB_CNT_L:  r_count[7:0]   <= i_ctl.wdata;
                ftu_pkg::SUB_CMPA_H: r_cmp_a[15:8]  <= i_ctl.wdata;
                ftu_pkg::SUB_CMPA_L: r_cmp_a[7:0]   <= i_ctl.wdata;
                ftu_pkg::SUB_CMPB_H: r_cmp_b[15:8]  <= i_ctl.wdata;
                ftu_pkg::SUB_CMPB_L: r_cmp_b[7:0]   <= i_ctl.wdata;
                default:             r_ctl          <= r_ctl;
            endcase
        end
    end

    // register read mux
    always_comb begin
        o_stat.idle   = (r_ticks == '0);
        o_stat.raised = r_raised;
        unique case (i_ctl.sub)
            ftu_pkg::SUB_CTL:    o_stat.rdata = r_ctl;
            ftu_pkg::SUB_IOC:    o_stat.rdata = r_ioc;
            ftu_pkg::SUB_IER:    o_stat.rdata = ftu_pkg::FORCED_BITS | {5'd0, r_ier};
            ftu_pkg::SUB_STAT:   o_stat.rdata = ftu_pkg::FORCED_BITS | {5'd0, r_flags};
            ftu_pkg::SUB_CNT_H:  o_stat.rdata = r_count[15:8];
            ftu_pkg::SUB_CNT_L:  o_stat.rdata = r_count[7:0];
            ftu_pkg::SUB_CMPA_H: o_stat.rdata = r_cmp_a[15:8];
            ftu_pkg::SUB_CMPA_L: o_stat.rdata = r_cmp_a[7:0];
            ftu_pkg::SUB_CMPB_H: o_stat.rdata = r_cmp_b[15:8];
            ftu_pkg::SUB_CMPB_L: o_stat.rdata = r_cmp_b[7:0];
            default:             o_stat.rdata = '0;
        endcase
    end

endmodule
